FILE: design/ppl_pkg.sv
// Shared constants and types for the position PID loop with link watchdog.
package ppl_pkg;

  localparam int ANGLE_BITS = 13;

  localparam int ANGLE_W = 13;
  localparam int TURN_W  = 16;
  localparam int SPEED_W = 16;
  localparam int POS_W   = 29;
  localparam int GAIN_W  = 16;
  localparam int ILIM_W  = 31;
  localparam int OLIM_W  = 15;
  localparam int WIN_W   = 28;
  localparam int TICK_W  = 16;
  localparam int ACC_W   = 32;
  localparam int DRIVE_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int ERR_W   = POS_W + 1;
  localparam int PROD_W  = ERR_W + GAIN_W;
  localparam int FRAC_W  = 8;

  localparam logic [ILIM_W-1:0] ILIM_RST = ILIM_W'(30000);
  localparam logic [OLIM_W-1:0] OLIM_RST = OLIM_W'(7000);
  localparam logic [WIN_W-1:0]  WIN_RST  = WIN_W'(8192);
  localparam logic [TICK_W-1:0] TOUT_RST = TICK_W'(100);
  localparam logic [TICK_W-1:0] SETL_RST = TICK_W'(50);

  localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_PROP  = 3'd0,
    CFG_GAIN_INT   = 3'd1,
    CFG_GAIN_DERIV = 3'd2,
    CFG_ILIM       = 3'd3,
    CFG_OLIM       = 3'd4,
    CFG_WINDOW     = 3'd5,
    CFG_TIMEOUT    = 3'd6,
    CFG_SETTLE     = 3'd7
  } ppl_cfg_idx_t;

endpackage

FILE: design/pid_position_loop_with_watchdog_unit.sv
// Top level of the position PID loop with link watchdog and in-position latch.

// One beat in per cycle unless in_stall holds it, and one result beat out per input beat.
// A result is registered twice on its way out: the beat is captured in an input
// register, and a single compute step (three parallel multipliers, the integral
// clamp and the drive saturation) writes the loop state and the result register when the
// result side advances. While a finished result waits under out_stall, the input
// register still takes one more beat; after that in_stall follows out_stall, so
// throughput stays at one beat per cycle whenever the result side keeps up.
module pid_position_loop_with_watchdog_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ppl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ppl_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_encoder_fresh,
  input  logic [ppl_pkg::ANGLE_W-1:0]          in_raw_angle,
  input  logic signed [ppl_pkg::TURN_W-1:0]    in_turn_count,
  input  logic signed [ppl_pkg::SPEED_W-1:0]   in_speed,
  input  logic signed [ppl_pkg::POS_W-1:0]     in_setpoint,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [ppl_pkg::DRIVE_W-1:0]   out_drive,
  output logic                                 out_settled,
  output logic                                 out_link_lost,
  output logic signed [ppl_pkg::POS_W-1:0]     out_position
);
  import ppl_pkg::*;

  logic signed [GAIN_W-1:0] gain_prop_r, gain_int_r, gain_deriv_r;
  logic [ILIM_W-1:0]        ilim_r;
  logic [OLIM_W-1:0]        olim_r;
  logic [WIN_W-1:0]         window_r;
  logic [TICK_W-1:0]        timeout_r, settle_ticks_r;

  logic                     s1_vld_r;
  logic                     s1_fresh_r;
  logic [ANGLE_W-1:0]       s1_angle_r;
  logic signed [TURN_W-1:0] s1_turns_r;
  logic signed [SPEED_W-1:0] s1_speed_r;
  logic signed [POS_W-1:0]  s1_setpoint_r;

  logic signed [POS_W-1:0]  position_r, position_nxt;
  logic signed [ACC_W-1:0]  integral_r, integral_nxt;
  logic [TICK_W-1:0]        wait_r, wait_nxt;
  logic [TICK_W-1:0]        settle_r, settle_nxt;
  logic                     latch_r, latch_nxt;
  logic signed [POS_W-1:0]  target_r;
  logic                     lost_nxt;

  logic                     advance;
  logic [31:0]              raw_pos;
  logic [TICK_W:0]          wait_inc, settle_inc;
  logic                     latch_tmp, close;
  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W:0]    err_ext, win_ext;
  logic signed [PROD_W-1:0] prod_p, prod_i;
  logic signed [31:0]       prod_d;
  logic signed [ACC_W+6:0]  acc_sum, ilim_ext;
  logic signed [ACC_W+8:0]  drv_sum, olim_ext;
  logic signed [DRIVE_W-1:0] drive_nxt;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_vld_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_prop_r    <= '0;
      gain_int_r     <= '0;
      gain_deriv_r   <= '0;
      ilim_r         <= ILIM_RST;
      olim_r         <= OLIM_RST;
      window_r       <= WIN_RST;
      timeout_r      <= TOUT_RST;
      settle_ticks_r <= SETL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (ppl_cfg_idx_t'(cfg_index))
        CFG_GAIN_PROP:  gain_prop_r    <= signed'(cfg_data[GAIN_W-1:0]);
        CFG_GAIN_INT:   gain_int_r     <= signed'(cfg_data[GAIN_W-1:0]);
        CFG_GAIN_DERIV: gain_deriv_r   <= signed'(cfg_data[GAIN_W-1:0]);
        CFG_ILIM:       ilim_r         <= cfg_data[ILIM_W-1:0];
        CFG_OLIM:       olim_r         <= cfg_data[OLIM_W-1:0];
        CFG_WINDOW:     window_r       <= cfg_data[WIN_W-1:0];
        CFG_TIMEOUT:    timeout_r      <= cfg_data[TICK_W-1:0];
        CFG_SETTLE:     settle_ticks_r <= cfg_data[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_fresh_r    <= in_encoder_fresh;
      s1_angle_r    <= in_raw_angle;
      s1_turns_r    <= in_turn_count;
      s1_speed_r    <= in_speed;
      s1_setpoint_r <= in_setpoint;
    end
  end

  always_comb begin
    raw_pos = (32'(s1_turns_r) << ANGLE_BITS) + (32'(s1_angle_r) & ANGLE_MASK);
    position_nxt = s1_fresh_r ? signed'(raw_pos[POS_W-1:0]) : position_r;

    wait_inc = {1'b0, wait_r} + 1'b1;
    lost_nxt = 1'b0;
    if (s1_fresh_r) begin
      wait_nxt = TICK_W'(1);
    end else if (wait_inc > {1'b0, timeout_r}) begin
      wait_nxt = TICK_W'(1);
      lost_nxt = 1'b1;
    end else begin
      wait_nxt = wait_inc[TICK_W-1:0];
    end

    latch_tmp = (s1_setpoint_r != target_r) ? 1'b0 : latch_r;
    err       = ERR_W'(s1_setpoint_r) - ERR_W'(position_nxt);
    err_ext   = (ERR_W+1)'(err);
    win_ext   = signed'({{(ERR_W+1-WIN_W){1'b0}}, window_r});
    close     = (err_ext < win_ext) && (err_ext > -win_ext);
    settle_inc = close ? ({1'b0, settle_r} + 1'b1) : '0;
    if (settle_inc > {1'b0, settle_ticks_r}) begin
      settle_nxt = settle_ticks_r;
      latch_nxt  = 1'b1;
    end else begin
      settle_nxt = settle_inc[TICK_W-1:0];
      latch_nxt  = latch_tmp;
    end

    prod_p = err * gain_prop_r;
    prod_i = err * gain_int_r;
    prod_d = s1_speed_r * gain_deriv_r;

    acc_sum  = (ACC_W+7)'(integral_r) + (ACC_W+7)'(signed'(prod_i[PROD_W-1:FRAC_W]));
    ilim_ext = signed'({{(ACC_W+7-ILIM_W){1'b0}}, ilim_r});
    if (acc_sum > ilim_ext) begin
      integral_nxt = ACC_W'(ilim_ext);
    end else if (acc_sum < -ilim_ext) begin
      integral_nxt = ACC_W'(-ilim_ext);
    end else begin
      integral_nxt = ACC_W'(acc_sum);
    end

    drv_sum  = (ACC_W+9)'(signed'(prod_p[PROD_W-1:FRAC_W])) + (ACC_W+9)'(integral_nxt)
             - (ACC_W+9)'(signed'(prod_d[31:FRAC_W]));
    olim_ext = signed'({{(ACC_W+9-OLIM_W){1'b0}}, olim_r});
    if (drv_sum > olim_ext) begin
      drive_nxt = DRIVE_W'(olim_ext);
    end else if (drv_sum < -olim_ext) begin
      drive_nxt = DRIVE_W'(-olim_ext);
    end else begin
      drive_nxt = DRIVE_W'(drv_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
      integral_r <= '0;
      wait_r     <= '0;
      settle_r   <= '0;
      latch_r    <= 1'b0;
      target_r   <= '0;
      out_valid  <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_vld_r;
      if (s1_vld_r) begin
        position_r <= position_nxt;
        integral_r <= integral_nxt;
        wait_r     <= wait_nxt;
        settle_r   <= settle_nxt;
        latch_r    <= latch_nxt;
        target_r   <= s1_setpoint_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_vld_r) begin
      out_drive     <= drive_nxt;
      out_settled   <= latch_nxt;
      out_link_lost <= lost_nxt;
      out_position  <= position_nxt;
    end
  end

endmodule

FILE: design/ppl_chk.sv
// Port-level checker for the position PID loop, bound to the top level.
module ppl_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [ppl_pkg::DRIVE_W-1:0]   out_drive,
  input logic                                 out_settled,
  input logic                                 out_link_lost,
  input logic signed [ppl_pkg::POS_W-1:0]     out_position
);
  import ppl_pkg::*;

  a_reset_clears_out : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_drive_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_drive != {1'b1, {(DRIVE_W-1){1'b0}}})
    else $error("drive reached the most negative code");

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive)
      && $stable(out_position) && $stable(out_settled) && $stable(out_link_lost))
    else $error("stalled result beat changed");

  a_in_flow : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the result side was free");

  a_no_stall_when_out_free : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while result register empty");

endmodule

bind pid_position_loop_with_watchdog_unit ppl_chk u_ppl_chk (.*);

FILE: verif/pid_position_loop_with_watchdog_unit_tb.sv
// Self-checking testbench for the position PID loop with link watchdog and in-position latch.
module pid_position_loop_with_watchdog_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppl_pkg::*;

  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned REPORT_MAX     = 10;

  typedef struct {
    bit                        fresh;
    logic [ANGLE_W-1:0]        angle;
    logic signed [TURN_W-1:0]  turns;
    logic signed [SPEED_W-1:0] spd;
    logic signed [POS_W-1:0]   setpoint;
  } tick_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      in_pos;
    logic                      lost;
    logic signed [POS_W-1:0]   pos;
  } axis_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_encoder_fresh = 1'b0;
  logic [ANGLE_W-1:0] in_raw_angle = '0;
  logic signed [TURN_W-1:0] in_turn_count = '0;
  logic signed [SPEED_W-1:0] in_speed = '0;
  logic signed [POS_W-1:0] in_setpoint = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DRIVE_W-1:0] out_drive;
  logic out_settled;
  logic out_link_lost;
  logic signed [POS_W-1:0] out_position;

  pid_position_loop_with_watchdog_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_encoder_fresh (in_encoder_fresh),
    .in_raw_angle     (in_raw_angle),
    .in_turn_count    (in_turn_count),
    .in_speed         (in_speed),
    .in_setpoint      (in_setpoint),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_drive        (out_drive),
    .out_settled      (out_settled),
    .out_link_lost    (out_link_lost),
    .out_position     (out_position)
  );

  always #2 clk = ~clk;

  // Loop settings as the block should hold them.
  logic signed [GAIN_W-1:0] kp = '0;
  logic signed [GAIN_W-1:0] ki = '0;
  logic signed [GAIN_W-1:0] kd = '0;
  longint ilim = 30000;
  longint olim = 7000;
  longint win = 8192;
  int unsigned tout = 100;
  int unsigned tsettle = 50;

  // Loop state as the block should hold it.
  logic signed [POS_W-1:0] held_pos = '0;
  logic signed [POS_W-1:0] last_sp = '0;
  longint integ = 0;
  int unsigned wait_cnt = 0;
  int unsigned settle_cnt = 0;
  bit latched = 1'b0;

  axis_cmd_t pending_cmds[$];

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  bit hold_go = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned ticks_sent = 0;
  int unsigned cmds_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned lost_seen = 0;
  int unsigned settled_seen = 0;

  function automatic longint clip(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic axis_cmd_t step_axis(tick_t t);
    longint err;
    longint acc;
    longint drv;
    axis_cmd_t r;
    r.lost = 1'b0;
    if (t.fresh) begin
      held_pos = signed'({t.turns, t.angle});
      wait_cnt = 1;
    end else begin
      wait_cnt++;
      if (wait_cnt > tout) begin
        r.lost = 1'b1;
        wait_cnt = 1;
      end
    end
    if (t.setpoint != last_sp) begin
      latched = 1'b0;
      last_sp = t.setpoint;
    end
    err = longint'(t.setpoint) - longint'(held_pos);
    if (err < win && err > -win) settle_cnt++;
    else settle_cnt = 0;
    if (settle_cnt > tsettle) begin
      settle_cnt = tsettle;
      latched = 1'b1;
    end
    acc = clip(integ + ((err * longint'(ki)) >>> 8), ilim);
    integ = acc;
    drv = ((err * longint'(kp)) >>> 8) + acc - ((longint'(t.spd) * longint'(kd)) >>> 8);
    drv = clip(drv, olim);
    r.drive = drv[DRIVE_W-1:0];
    r.in_pos = latched;
    r.pos = held_pos;
    return r;
  endfunction

  function automatic tick_t make_tick(bit fresh, logic [POS_W-1:0] pos,
                                      logic signed [SPEED_W-1:0] spd,
                                      logic signed [POS_W-1:0] setpoint);
    tick_t t;
    t.fresh = fresh;
    t.angle = pos[ANGLE_W-1:0];
    t.turns = pos[POS_W-1:ANGLE_W];
    t.spd = spd;
    t.setpoint = setpoint;
    return t;
  endfunction

  task automatic send_tick(tick_t t);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_encoder_fresh <= t.fresh;
    in_raw_angle <= t.angle;
    in_turn_count <= t.turns;
    in_speed <= t.spd;
    in_setpoint <= t.setpoint;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_cmds.push_back(step_axis(t));
    ticks_sent++;
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(ppl_cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    drain_pipe();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_GAIN_PROP:  kp = data[GAIN_W-1:0];
      CFG_GAIN_INT:   ki = data[GAIN_W-1:0];
      CFG_GAIN_DERIV: kd = data[GAIN_W-1:0];
      CFG_ILIM:       ilim = longint'(data[ILIM_W-1:0]);
      CFG_OLIM:       olim = longint'(data[OLIM_W-1:0]);
      CFG_WINDOW:     win = longint'(data[WIN_W-1:0]);
      CFG_TIMEOUT:    tout = 32'(data[TICK_W-1:0]);
      CFG_SETTLE:     tsettle = 32'(data[TICK_W-1:0]);
      default: begin
      end
    endcase
  endtask

  task automatic write_all(logic [31:0] p, logic [31:0] i, logic [31:0] d, logic [31:0] il,
                           logic [31:0] ol, logic [31:0] w, logic [31:0] to,
                           logic [31:0] st);
    write_reg(CFG_GAIN_PROP, p);
    write_reg(CFG_GAIN_INT, i);
    write_reg(CFG_GAIN_DERIV, d);
    write_reg(CFG_ILIM, il);
    write_reg(CFG_OLIM, ol);
    write_reg(CFG_WINDOW, w);
    write_reg(CFG_TIMEOUT, to);
    write_reg(CFG_SETTLE, st);
  endtask

  task automatic check_cmd();
    axis_cmd_t got;
    axis_cmd_t want;
    got.drive = out_drive;
    got.in_pos = out_settled;
    got.lost = out_link_lost;
    got.pos = out_position;
    if (pending_cmds.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("Unexpected result beat: drive %0d position %0d", got.drive, got.pos);
    end else begin
      want = pending_cmds.pop_front();
      cmds_checked++;
      if (got.lost) lost_seen++;
      if (got.in_pos) settled_seen++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display({"Result %0d: drive exp %0d got %0d, settled exp %0b got %0b, ",
                    "link_lost exp %0b got %0b, position exp %0d got %0d"},
                   cmds_checked, want.drive, got.drive, want.in_pos, got.in_pos,
                   want.lost, got.lost, want.pos, got.pos);
      end
    end
  endtask

  initial begin
    int unsigned hold_left;
    bit hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) check_cmd();
      if (hold_go != hold_seen) begin
        hold_seen = hold_go;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic test_power_on();
    send_tick(make_tick(1'b1, 29'd100, 16'sd0, 29'sd0));
    send_tick(make_tick(1'b0, 29'd0, 16'sd10, 29'sd0));
    send_tick(make_tick(1'b1, -29'sd1, -16'sd10, 29'sd5));
  endtask

  task automatic test_extremes();
    write_all(32'h0000_7fff, 32'hffff_8000, 32'h1234_8000, 32'hffff_ffff,
              32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_tick(make_tick(1'b1, 29'h0fff_ffff, -16'sd32768, -29'sd268435456));
    send_tick(make_tick(1'b1, 29'h1000_0000, 16'sd32767, 29'sd268435455));
    send_tick(make_tick(1'b0, 29'd0, 16'sd32767, 29'sd268435455));
    send_tick(make_tick(1'b1, -29'sd1, -16'sd32768, 29'sd0));
    send_tick(make_tick(1'b0, 29'd4096, 16'sd0, -29'sd1));
    write_reg(CFG_OLIM, 32'h0000_0000);
    write_reg(CFG_ILIM, 32'h8000_0000);
    send_tick(make_tick(1'b1, 29'd100, 16'sd500, 29'sd12345));
    send_tick(make_tick(1'b0, 29'd0, -16'sd500, 29'sd12345));
  endtask

  task automatic test_zero_timeout();
    write_all(32'd256, 32'd16, 32'd64, 32'd50000, 32'd20000, 32'd100, 32'd0, 32'd0);
    send_tick(make_tick(1'b0, 29'd0, 16'sd3, 29'sd2000));
    send_tick(make_tick(1'b0, 29'd0, 16'sd3, 29'sd2000));
    send_tick(make_tick(1'b1, 29'd1990, 16'sd3, 29'sd2000));
    send_tick(make_tick(1'b0, 29'd0, 16'sd3, 29'sd2000));
  endtask

  task automatic test_settle_latch();
    write_reg(CFG_TIMEOUT, 32'd3);
    write_reg(CFG_WINDOW, 32'd16);
    write_reg(CFG_SETTLE, 32'd2);
    send_tick(make_tick(1'b1, 29'd1000, 16'sd0, 29'sd1000));
    send_tick(make_tick(1'b1, 29'd1003, 16'sd0, 29'sd1000));
    send_tick(make_tick(1'b0, 29'd0, 16'sd0, 29'sd1000));
    send_tick(make_tick(1'b0, 29'd0, 16'sd0, 29'sd1000));
    send_tick(make_tick(1'b0, 29'd0, 16'sd0, 29'sd1005));
    write_reg(CFG_WINDOW, 32'd0);
    send_tick(make_tick(1'b1, 29'd1005, 16'sd0, 29'sd1005));
    send_tick(make_tick(1'b1, 29'd1005, 16'sd0, 29'sd1005));
  endtask

  task automatic randomize_loop();
    write_all($urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 4095)) - 32'd2048,
              $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 1023)) - 32'd512,
              $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 1023)) - 32'd512,
              $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200000),
              $urandom,
              $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 30000),
              $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 25),
              $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 10));
  endtask

  // Segments hold one setpoint while the position converges on it; a few beats are noise.
  task automatic run_segments(int unsigned n_ticks);
    int unsigned done;
    int unsigned seg_len;
    int unsigned fresh_pct;
    int unsigned spread;
    int off;
    logic signed [POS_W-1:0] sp;
    logic signed [POS_W-1:0] pos;
    logic signed [SPEED_W-1:0] spd;
    done = 0;
    while (done < n_ticks) begin
      sp = POS_W'($urandom);
      seg_len = $urandom_range(4, 40);
      case ($urandom_range(0, 3))
        0: fresh_pct = 100;
        1: fresh_pct = 70;
        2: fresh_pct = 20;
        default: fresh_pct = 0;
      endcase
      spread = $urandom_range(0, 40000);
      for (int i = 0; i < seg_len && done < n_ticks; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_tick(make_tick(1'($urandom_range(0, 1)), POS_W'($urandom),
                              SPEED_W'($urandom), POS_W'($urandom)));
        end else begin
          off = int'($urandom_range(0, 2 * spread)) - int'(spread);
          pos = sp + POS_W'(off);
          spd = $urandom_range(0, 1) ? SPEED_W'($urandom)
                                     : SPEED_W'(int'($urandom_range(0, 200)) - 100);
          send_tick(make_tick(i == 0 || $urandom_range(99) < fresh_pct, pos, spd, sp));
          spread = spread * 3 / 4;
        end
        done++;
      end
    end
  endtask

  task automatic test_random_traffic();
    int unsigned idle_mix[4] = '{0, 64, 0, 31};
    int unsigned stall_mix[4] = '{0, 0, 64, 31};
    for (int ph = 0; ph < 4; ph++) begin
      drain_pipe();
      idle_pct = idle_mix[ph];
      stall_pct = stall_mix[ph];
      for (int half = 0; half < 2; half++) begin
        randomize_loop();
        run_segments(190);
      end
    end
    drain_pipe();
    idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_output_hold();
    randomize_loop();
    hold_go <= ~hold_go;
    run_segments(40);
    drain_pipe();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_power_on();
    test_extremes();
    test_zero_timeout();
    test_settle_latch();
    test_random_traffic();
    test_output_hold();
    drain_pipe();
    repeat (10) @(posedge clk);
    $display("Ran %0d control ticks and %0d register writes under four idle and stall mixes",
             ticks_sent, reg_writes);
    $display("plus one long output hold; %0d watchdog and %0d in-position results checked.",
             lost_seen, settled_seen);
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
